### rtl/bclt_pkg.sv
// shared constants and types for the button click / long-press led timer
package bclt_pkg;

   localparam int CFG_WIDTH           = 16;
   localparam int CLICK_WIDTH         = 16;
   localparam int DEFAULT_TIMER_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH     = 2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RESET   = CFG_WIDTH'(50);
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_TICKS_RESET = CFG_WIDTH'(2000);
   localparam logic [CFG_WIDTH-1:0] OFF_TICKS_RESET        = CFG_WIDTH'(10000);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS   = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_TICKS        = CSR_INDEX_WIDTH'(2);

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] long_press_ticks;
      logic [CFG_WIDTH-1:0] off_ticks;
   } cfg_type;

   typedef struct packed {
      logic                   led_on;
      logic                   click_seen;
      logic                   long_press_seen;
      logic [CLICK_WIDTH-1:0] click_total;
   } result_type;

endpackage

### rtl/bclt_engine.sv
// button state registers and per-tick update logic
module bclt_engine
   import bclt_pkg::*;
#(
   parameter int TIMER_WIDTH = DEFAULT_TIMER_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       button_level,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};

   logic                   last_raw_level_ff, last_raw_level_in;
   logic [TIMER_WIDTH-1:0] since_edge_count_ff, since_edge_count_in;
   logic                   press_active_ff, press_active_in;
   logic                   long_fired_ff, long_fired_in;
   logic [TIMER_WIDTH-1:0] press_elapsed_ff, press_elapsed_in;
   logic                   led_state_ff, led_state_in;
   logic                   off_timer_running_ff, off_timer_running_in;
   logic [TIMER_WIDTH-1:0] off_timer_count_ff, off_timer_count_in;
   logic [CLICK_WIDTH-1:0] click_counter_ff, click_counter_in;

   logic click;
   logic longp;
   logic new_press;

   always_comb begin
      last_raw_level_in    = button_level;
      since_edge_count_in  = since_edge_count_ff;
      press_active_in      = press_active_ff;
      long_fired_in        = long_fired_ff;
      press_elapsed_in     = press_elapsed_ff;
      led_state_in         = led_state_ff;
      off_timer_running_in = off_timer_running_ff;
      off_timer_count_in   = off_timer_count_ff;
      click_counter_in     = click_counter_ff;
      click                = 1'b0;
      longp                = 1'b0;
      new_press            = 1'b0;

      // one-shot off timer
      if (off_timer_running_ff) begin
         off_timer_count_in = (off_timer_count_ff == CNT_MAX) ? CNT_MAX
                              : off_timer_count_ff + TIMER_WIDTH'(1);
         if (CMP_WIDTH'(off_timer_count_in) >= CMP_WIDTH'(cfg.off_ticks)) begin
            led_state_in         = 1'b0;
            off_timer_running_in = 1'b0;
         end
      end

      // debounced edge
      if ((button_level != last_raw_level_ff) &&
          (CMP_WIDTH'(since_edge_count_ff) > CMP_WIDTH'(cfg.debounce_ticks))) begin
         since_edge_count_in = '0;
         if (!button_level) begin
            press_active_in  = 1'b1;
            long_fired_in    = 1'b0;
            press_elapsed_in = '0;
            new_press        = 1'b1;
         end else begin
            press_active_in = 1'b0;
            if (!long_fired_ff) begin
               click                = 1'b1;
               click_counter_in     = click_counter_ff + CLICK_WIDTH'(1);
               led_state_in         = 1'b1;
               off_timer_running_in = 1'b1;
               off_timer_count_in   = '0;
            end
         end
      end else begin
         since_edge_count_in = (since_edge_count_ff == CNT_MAX) ? CNT_MAX
                               : since_edge_count_ff + TIMER_WIDTH'(1);
      end

      // long press
      if (press_active_in && !new_press) begin
         press_elapsed_in = (press_elapsed_ff == CNT_MAX) ? CNT_MAX
                            : press_elapsed_ff + TIMER_WIDTH'(1);
      end
      if (press_active_in && !long_fired_in &&
          (CMP_WIDTH'(press_elapsed_in) >= CMP_WIDTH'(cfg.long_press_ticks))) begin
         led_state_in         = 1'b0;
         off_timer_running_in = 1'b0;
         long_fired_in        = 1'b1;
         longp                = 1'b1;
      end
   end

   assign result.led_on          = led_state_in;
   assign result.click_seen      = click;
   assign result.long_press_seen = longp;
   assign result.click_total     = click_counter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_level_ff    <= 1'b1;
         since_edge_count_ff  <= '0;
         press_active_ff      <= 1'b0;
         long_fired_ff        <= 1'b0;
         press_elapsed_ff     <= '0;
         led_state_ff         <= 1'b0;
         off_timer_running_ff <= 1'b0;
         off_timer_count_ff   <= '0;
         click_counter_ff     <= '0;
      end else if (step) begin
         last_raw_level_ff    <= last_raw_level_in;
         since_edge_count_ff  <= since_edge_count_in;
         press_active_ff      <= press_active_in;
         long_fired_ff        <= long_fired_in;
         press_elapsed_ff     <= press_elapsed_in;
         led_state_ff         <= led_state_in;
         off_timer_running_ff <= off_timer_running_in;
         off_timer_count_ff   <= off_timer_count_in;
         click_counter_ff     <= click_counter_in;
      end
   end

endmodule

### rtl/button_click_longpress_led_timer.sv
// top level: debounced click / long-press detector with led auto-off timer
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_ready button_level
//   rsp      out        rsp_valid/rsp_ready led_on, click_seen, long_press_seen, click_total
//   csr      in         csr_write           csr_index, csr_data
//
// state and result register update on the accepting edge
// the result register frees when taken, so a new transaction enters the same cycle
// req_ready drops only while a result is held and rsp_ready is low
// synchronous reset restores the register defaults and the released-button state
module button_click_longpress_led_timer
   import bclt_pkg::*;
#(
   parameter int TIMER_WIDTH = DEFAULT_TIMER_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_button_level,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_led_on,
   output logic                       rsp_click_seen,
   output logic                       rsp_long_press_seen,
   output logic [CLICK_WIDTH-1:0]     rsp_click_total,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   cfg_type    cfg_ff;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_accept   = req_valid && req_ready;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_TICKS_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_TICKS_RESET;
         cfg_ff.off_ticks        <= OFF_TICKS_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_DEBOUNCE_TICKS) begin
            cfg_ff.debounce_ticks <= csr_data;
         end
         if (csr_index == CSR_LONG_PRESS_TICKS) begin
            cfg_ff.long_press_ticks <= csr_data;
         end
         if (csr_index == CSR_OFF_TICKS) begin
            cfg_ff.off_ticks <= csr_data;
         end
      end
   end

   bclt_engine #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (req_accept),
      .button_level(req_button_level),
      .cfg         (cfg_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_led_on          = result_ff.led_on;
   assign rsp_click_seen      = result_ff.click_seen;
   assign rsp_long_press_seen = result_ff.long_press_seen;
   assign rsp_click_total     = result_ff.click_total;

endmodule
